// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in rst.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/fwas_pkg.sv =====
// ---------------------------------------------------------------------------
// Scroller package
// Widths, codes, reset values and shared types of the four-way scroller.
// ---------------------------------------------------------------------------
package fwas_pkg;

  localparam int unsigned NUM_CHAN   = 4;
  localparam int unsigned SPEED_W    = 28;
  localparam int unsigned ACCEL_W    = 16;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned TIME_W     = 16;
  localparam int unsigned MOVE_W     = 20;
  localparam int unsigned COUNT_W    = 3;
  localparam int unsigned DIR_W      = 2;
  localparam int unsigned REG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 28;
  localparam int unsigned TIME_DROP  = 8;
  localparam int unsigned ACC_SHIFT  = 14;
  localparam int unsigned PROD_W     = SPEED_W + TIME_W;

  localparam logic [SPEED_W-1:0] INITIAL_SPEED_RST = 28'h001_0000;
  localparam logic [ACCEL_W-1:0] ACCEL_RST         = 16'h4000;
  localparam logic [SPEED_W-1:0] MAX_SPEED_RST     = 28'h010_0000;

  typedef enum logic [0:0] {
    OP_TICK   = 1'b0,
    OP_CHANGE = 1'b1
  } op_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_INITIAL_SPEED = 2'd0,
    REG_ACCEL         = 2'd1,
    REG_MAX_SPEED     = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [SPEED_W-1:0] initial_speed;
    logic [ACCEL_W-1:0] acceleration_factor;
    logic [SPEED_W-1:0] max_speed;
  } cfg_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic [FRAC_W-1:0]  fraction;
  } chan_state_t;

  typedef struct packed {
    op_t                operation;
    logic [DIR_W-1:0]   direction;
    logic               enable;
    logic [TIME_W-1:0]  time_step;
  } item_t;

endpackage

// ===== hdl/fwas_ifs.sv =====
// ---------------------------------------------------------------------------
// Scroller channel interfaces
// Valid/ready channels for input items, results and register writes.
// ---------------------------------------------------------------------------
interface fwas_item_if;
  logic                           valid;
  logic                           ready;
  logic                           operation;
  logic [fwas_pkg::DIR_W-1:0]     direction;
  logic                           enable;
  logic [fwas_pkg::TIME_W-1:0]    time_step;

  modport source (output valid, operation, direction, enable, time_step, input ready);
  modport sink   (input valid, operation, direction, enable, time_step, output ready);
endinterface

interface fwas_result_if;
  logic                           valid;
  logic                           ready;
  logic [fwas_pkg::MOVE_W-1:0]    move_left;
  logic [fwas_pkg::MOVE_W-1:0]    move_right;
  logic [fwas_pkg::MOVE_W-1:0]    move_up;
  logic [fwas_pkg::MOVE_W-1:0]    move_down;
  logic [fwas_pkg::COUNT_W-1:0]   moved_count;

  modport source (output valid, move_left, move_right, move_up, move_down, moved_count,
                  input ready);
  modport sink   (input valid, move_left, move_right, move_up, move_down, moved_count,
                  output ready);
endinterface

interface fwas_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [fwas_pkg::REG_IDX_W-1:0]   index;
  logic [fwas_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/fwas_regs.sv =====
// ---------------------------------------------------------------------------
// Scroller configuration registers
// Initial speed, acceleration factor and speed ceiling, written by index.
// ---------------------------------------------------------------------------
module fwas_regs (
  input  logic           clk,
  input  logic           rst,
  fwas_cfg_if.sink       cfg,
  output fwas_pkg::cfg_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.initial_speed       <= fwas_pkg::INITIAL_SPEED_RST;
      regs.acceleration_factor <= fwas_pkg::ACCEL_RST;
      regs.max_speed           <= fwas_pkg::MAX_SPEED_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        fwas_pkg::REG_INITIAL_SPEED: begin
          regs.initial_speed <= cfg.data[fwas_pkg::SPEED_W-1:0];
        end
        fwas_pkg::REG_ACCEL: begin
          regs.acceleration_factor <= cfg.data[fwas_pkg::ACCEL_W-1:0];
        end
        fwas_pkg::REG_MAX_SPEED: begin
          regs.max_speed <= cfg.data[fwas_pkg::SPEED_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hdl/fwas_channel.sv =====
// ---------------------------------------------------------------------------
// Scroller channel datapath
// Distance accumulation, whole-pixel move and capped speed scaling on a tick.
// ---------------------------------------------------------------------------
module fwas_channel (
  input  logic                           eligible,
  input  fwas_pkg::chan_state_t          cur,
  input  logic [fwas_pkg::TIME_W-1:0]    time_step,
  input  fwas_pkg::cfg_t                 regs,
  output fwas_pkg::chan_state_t          adv,
  output logic [fwas_pkg::MOVE_W-1:0]    move
);

  localparam int unsigned SUM_W    = fwas_pkg::PROD_W - fwas_pkg::TIME_DROP + 1;
  localparam int unsigned SCALED_W = fwas_pkg::PROD_W - fwas_pkg::ACC_SHIFT;

  logic [fwas_pkg::PROD_W-1:0] dist_prod;
  logic [fwas_pkg::PROD_W-1:0] acc_prod;
  logic [SUM_W-1:0]            sum;
  logic [SCALED_W-1:0]         scaled;

  assign dist_prod = fwas_pkg::PROD_W'(cur.speed) * fwas_pkg::PROD_W'(time_step);
  assign sum       = SUM_W'(dist_prod[fwas_pkg::PROD_W-1:fwas_pkg::TIME_DROP])
                   + SUM_W'(cur.fraction);
  assign acc_prod  = fwas_pkg::PROD_W'(cur.speed) * fwas_pkg::PROD_W'(regs.acceleration_factor);
  assign scaled    = acc_prod[fwas_pkg::PROD_W-1:fwas_pkg::ACC_SHIFT];

  always_comb begin
    adv.fraction = sum[fwas_pkg::FRAC_W-1:0];
    if (scaled > SCALED_W'(regs.max_speed)) begin
      adv.speed = regs.max_speed;
    end else begin
      adv.speed = scaled[fwas_pkg::SPEED_W-1:0];
    end
    move = eligible ? sum[fwas_pkg::FRAC_W +: fwas_pkg::MOVE_W] : '0;
  end

endmodule

// ===== hdl/four_way_accelerating_scroller.sv =====
// ---------------------------------------------------------------------------
// Four-way accelerating scroller
// Path: the item passes the input register, then the result register, and the result
//   is held until the result transfer; throughput: one item per cycle, stalled only
//   by result back-pressure.
// Channel state is updated as the item leaves the input register, so the next
//   item sees it at once. Reset stops all channels and loads default registers.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module four_way_accelerating_scroller (
  input  logic           clk,
  input  logic           rst,
  fwas_item_if.sink      item,
  fwas_result_if.source  result,
  fwas_cfg_if.sink       cfg
);

  fwas_pkg::cfg_t                                   regs;
  fwas_pkg::item_t                                  stage;
  logic                                             stage_valid;
  logic                                             stage_fire;
  logic                                             result_valid;
  logic [fwas_pkg::NUM_CHAN-1:0]                    running;
  logic [fwas_pkg::NUM_CHAN-1:0]                    running_next;
  fwas_pkg::chan_state_t                            chans      [fwas_pkg::NUM_CHAN];
  fwas_pkg::chan_state_t                            chans_next [fwas_pkg::NUM_CHAN];
  fwas_pkg::chan_state_t                            adv        [fwas_pkg::NUM_CHAN];
  logic [fwas_pkg::NUM_CHAN-1:0]                    eligible;
  logic [fwas_pkg::NUM_CHAN-1:0][fwas_pkg::MOVE_W-1:0] moves;
  logic [fwas_pkg::COUNT_W-1:0]                     count;
  logic [fwas_pkg::NUM_CHAN-1:0][fwas_pkg::MOVE_W-1:0] res_move;
  logic [fwas_pkg::COUNT_W-1:0]                     res_count;
  logic [fwas_pkg::NUM_CHAN-1:0]                    res_nz;
  logic [fwas_pkg::COUNT_W-1:0]                     res_nz_count;
  logic                                             res_opposed;
  logic                                             change_fire;

  fwas_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  assign stage_fire = stage_valid && (!result_valid || result.ready);
  assign item.ready = !stage_valid || stage_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item.ready) begin
      stage_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      stage.operation <= fwas_pkg::op_t'(item.operation);
      stage.direction <= item.direction;
      stage.enable    <= item.enable;
      stage.time_step <= item.time_step;
    end
  end

  for (genvar g = 0; g < fwas_pkg::NUM_CHAN; g++) begin : g_chan
    assign eligible[g] = running[g] && !running[g ^ 1];
    fwas_channel u_chan (
      .eligible  (eligible[g]),
      .cur       (chans[g]),
      .time_step (stage.time_step),
      .regs      (regs),
      .adv       (adv[g]),
      .move      (moves[g])
    );
  end

  always_comb begin
    running_next = running;
    for (int i = 0; i < fwas_pkg::NUM_CHAN; i++) begin
      chans_next[i] = chans[i];
    end
    count = '0;
    unique case (stage.operation)
      fwas_pkg::OP_CHANGE: begin
        if (stage.enable && !running[stage.direction]) begin
          running_next[stage.direction]     = 1'b1;
          chans_next[stage.direction].speed = regs.initial_speed;
        end else if (!stage.enable && running[stage.direction]) begin
          running_next[stage.direction]        = 1'b0;
          chans_next[stage.direction].fraction = '0;
        end
      end
      fwas_pkg::OP_TICK: begin
        for (int i = 0; i < fwas_pkg::NUM_CHAN; i++) begin
          if (eligible[i]) begin
            chans_next[i] = adv[i];
          end
          if (moves[i] != '0) begin
            count = count + fwas_pkg::COUNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= '0;
      for (int i = 0; i < fwas_pkg::NUM_CHAN; i++) begin
        chans[i] <= '0;
      end
    end else if (stage_fire) begin
      running <= running_next;
      for (int i = 0; i < fwas_pkg::NUM_CHAN; i++) begin
        chans[i] <= chans_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (stage_fire) begin
      result_valid <= 1'b1;
    end else if (result.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_fire) begin
      if (stage.operation == fwas_pkg::OP_TICK) begin
        res_move  <= moves;
        res_count <= count;
      end else begin
        res_move  <= '0;
        res_count <= '0;
      end
    end
  end

  assign result.valid       = result_valid;
  assign result.move_left   = res_move[0];
  assign result.move_right  = res_move[1];
  assign result.move_up     = res_move[2];
  assign result.move_down   = res_move[3];
  assign result.moved_count = res_count;

  always_comb begin
    for (int i = 0; i < fwas_pkg::NUM_CHAN; i++) begin
      res_nz[i] = (res_move[i] != '0);
    end
  end

  assign res_nz_count = fwas_pkg::COUNT_W'($countones(res_nz));
  assign res_opposed  = (res_nz[0] && res_nz[1]) || (res_nz[2] && res_nz[3]);
  assign change_fire  = stage_fire && (stage.operation == fwas_pkg::OP_CHANGE);

  `ASSERT_IMPLIES(a_count_matches, result_valid, res_count == res_nz_count, "moved count wrong")
  `ASSERT_IMPLIES(a_opposed_exclusive, result_valid, !res_opposed, "opposite channels both moved")
  `ASSERT_NEXT(a_change_silent, change_fire, res_nz == '0 && res_count == '0, "change moved")

endmodule
